>>> rtl/bloom_filter_insert_query_top_defines.svh
// Assertion macros shared by the Bloom filter RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef BLOOM_FILTER_INSERT_QUERY_TOP_DEFINES_SVH
`define BLOOM_FILTER_INSERT_QUERY_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bfq_pkg.sv
// Shared constants and types for the Bloom filter insert/query block.
// No dependencies; used by bfq_mod and bloom_filter_insert_query_top.
`default_nettype none

package bfq_pkg;

    // Storage sizes.
    localparam int MAX_WORDS     = 4096;
    localparam int MAX_FUNCTIONS = 16;
    localparam int WORD_AW       = $clog2(MAX_WORDS);
    localparam int FUNC_AW       = $clog2(MAX_FUNCTIONS);
    localparam int FUNC_CW       = $clog2(MAX_FUNCTIONS + 1);

    // Field widths.
    localparam int KEY_W         = 32;
    localparam int MODE_W        = 2;
    localparam int SHIFT_W       = 6;
    localparam int NUM_FUNC_W    = 5;
    localparam int FILTER_BITS_W = 18;
    localparam int BIT_SEL_W     = 5;
    localparam int CFG_IDX_W     = 2;

    // Remainder unit: bits of the dividend consumed per cycle.
    localparam int MOD_STEPS     = 4;
    localparam int MOD_CYCLES    = KEY_W / MOD_STEPS;
    localparam int MOD_CNT_W     = $clog2(MOD_CYCLES);

    // Command codes.
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FUNCTIONS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BITS   = 2'd1;

    // Configuration reset values.
    localparam logic [NUM_FUNC_W-1:0]    NUM_FUNCTIONS_RST = 5'd10;
    localparam logic [FILTER_BITS_W-1:0] FILTER_BITS_RST   = 18'd131072;

endpackage

`default_nettype wire

>>> rtl/bfq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/bfq_mod.sv
// Iterative restoring remainder unit: 32-bit dividend modulo an 18-bit divisor.
// Depends on bfq_pkg.
`default_nettype none

module bfq_mod (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [bfq_pkg::KEY_W-1:0]         i_dividend,
    input  wire logic [bfq_pkg::FILTER_BITS_W-1:0] i_divisor,
    output logic                                   o_done,
    output logic      [bfq_pkg::FILTER_BITS_W-1:0] o_rem
);

    localparam int RW = bfq_pkg::FILTER_BITS_W;

    logic                          r_busy;
    logic                          n_busy;
    logic                          r_done;
    logic                          n_done;
    logic [bfq_pkg::MOD_CNT_W-1:0] r_cnt;
    logic [bfq_pkg::MOD_CNT_W-1:0] n_cnt;
    logic [bfq_pkg::KEY_W-1:0]     r_dvd;
    logic [bfq_pkg::KEY_W-1:0]     n_dvd;
    logic [RW-1:0]                 r_rem;
    logic [RW-1:0]                 n_rem;
    logic [RW:0]                   v_rem;

    // Several compare-and-subtract steps per cycle on the partial remainder.
    always_comb begin
        v_rem = {1'b0, r_rem};
        for (int k = 0; k < bfq_pkg::MOD_STEPS; k++) begin
            v_rem = {v_rem[RW-1:0], r_dvd[bfq_pkg::KEY_W-1-k]};
            if (v_rem >= {1'b0, i_divisor}) begin
                v_rem = v_rem - {1'b0, i_divisor};
            end
        end
    end

    // Sequencing of the iterations.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = r_dvd << bfq_pkg::MOD_STEPS;
            n_rem = v_rem[RW-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == bfq_pkg::MOD_CNT_W'(bfq_pkg::MOD_CYCLES - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    // A zero-sized filter maps every hash to position zero.
    assign o_done = r_done;
    assign o_rem  = (i_divisor == '0) ? '0 : r_rem;

endmodule

`default_nettype wire

>>> rtl/bloom_filter_insert_query_top.sv
// Top level of the Bloom filter: command sequencer, hash tables and filter store.
// Depends on bfq_pkg, bfq_ram, bfq_mod and bloom_filter_insert_query_top_defines.svh.
//
// Usage:
// - Command channel: a transaction is taken at a rising edge with i_start high
//   and o_busy low. Mode 0 inserts i_key, mode 1 queries it, mode 2 loads
//   i_factor and i_shift_amount into hash slot i_func_index, mode 3 does nothing.
// - A load or an unused mode finishes in the accepting cycle; o_busy stays low.
// - Insert and query run the hash functions one after another through one
//   multiplier and one shared remainder unit. A query stops at the first
//   clear bit.
// - Each function passes through multiply, shift, the remainder unit (4 dividend
//   bits a cycle) and a read of the filter RAM, written back for an insert.
// - A query that passes every function pulses o_valid with o_key_out for one
//   cycle, together with the fall of o_busy. The receiver cannot stall the result.
// - Configuration: a transaction on i_cfg_valid/o_cfg_ready writes register
//   i_cfg_index (0 number of functions, 1 filter size in bits).
// - Reset clears the hash tables and then clears the 4096-word filter RAM one
//   word a cycle; o_busy stays high until the sweep is done.
`default_nettype none

`include "bloom_filter_insert_query_top_defines.svh"

module bloom_filter_insert_query_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic [bfq_pkg::MODE_W-1:0]        i_mode,
    input  wire logic [bfq_pkg::KEY_W-1:0]         i_key,
    input  wire logic [bfq_pkg::FUNC_AW-1:0]       i_func_index,
    input  wire logic [bfq_pkg::KEY_W-1:0]         i_factor,
    input  wire logic [bfq_pkg::SHIFT_W-1:0]       i_shift_amount,
    output logic                                   o_valid,
    output logic      [bfq_pkg::KEY_W-1:0]         o_key_out,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [bfq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bfq_pkg::FILTER_BITS_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_SHIFT,
        S_MOD,
        S_READ,
        S_CHECK
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    logic [bfq_pkg::WORD_AW-1:0]         r_clr_addr;
    logic [bfq_pkg::WORD_AW-1:0]         n_clr_addr;
    logic [bfq_pkg::FUNC_AW-1:0]         r_func;
    logic [bfq_pkg::FUNC_AW-1:0]         n_func;
    logic                                r_valid;
    logic                                n_valid;
    logic [bfq_pkg::MODE_W-1:0]          r_mode;
    logic [bfq_pkg::KEY_W-1:0]           r_key;
    logic [bfq_pkg::KEY_W-1:0]           r_key_out;
    logic [bfq_pkg::KEY_W-1:0]           r_prod;
    logic [bfq_pkg::FILTER_BITS_W-1:0]   r_pos;

    logic [bfq_pkg::NUM_FUNC_W-1:0]      r_num_functions;
    logic [bfq_pkg::FILTER_BITS_W-1:0]   r_filter_bits;
    logic [bfq_pkg::KEY_W-1:0]           r_factor [bfq_pkg::MAX_FUNCTIONS];
    logic [bfq_pkg::SHIFT_W-1:0]         r_shift  [bfq_pkg::MAX_FUNCTIONS];

    logic                                w_accept;
    logic                                w_run;
    logic [bfq_pkg::FUNC_CW-1:0]         w_active;
    logic                                w_last;
    logic [bfq_pkg::KEY_W-1:0]           w_prod;
    logic [bfq_pkg::SHIFT_W-1:0]         w_shift;
    logic [bfq_pkg::KEY_W-1:0]           w_hash;
    logic [bfq_pkg::KEY_W-1:0]           w_pos_ext;
    logic [bfq_pkg::WORD_AW-1:0]         w_word;
    logic [bfq_pkg::KEY_W-1:0]           w_mask;
    logic                                w_hit;
    logic                                w_mod_start;
    logic                                w_mod_done;
    logic [bfq_pkg::FILTER_BITS_W-1:0]   w_mod_rem;
    logic                                w_ram_we;
    logic [bfq_pkg::WORD_AW-1:0]         w_ram_waddr;
    logic [bfq_pkg::KEY_W-1:0]           w_ram_wdata;
    logic                                w_ram_re;
    logic [bfq_pkg::KEY_W-1:0]           w_ram_rdata;

    // Command handshake and the number of functions actually applied.
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !o_busy;
    assign w_run       = w_accept && ((i_mode == bfq_pkg::MODE_INSERT) ||
                                      (i_mode == bfq_pkg::MODE_QUERY));
    assign w_active    = (r_num_functions > bfq_pkg::NUM_FUNC_W'(bfq_pkg::MAX_FUNCTIONS))
                         ? bfq_pkg::FUNC_CW'(bfq_pkg::MAX_FUNCTIONS)
                         : bfq_pkg::FUNC_CW'(r_num_functions);
    assign w_last      = ({1'b0, r_func} == (w_active - 1'b1));

    // Hash datapath: multiply, then shift, then remainder in the shared unit.
    assign w_prod      = r_key * r_factor[r_func];
    assign w_shift     = r_shift[r_func];
    assign w_hash      = w_shift[bfq_pkg::SHIFT_W-1] ? '0
                         : (r_prod << w_shift[bfq_pkg::SHIFT_W-2:0]);
    assign w_mod_start = (r_state == S_SHIFT);

    // Word and bit selected by the bit position; the word index wraps.
    assign w_pos_ext   = bfq_pkg::KEY_W'(r_pos);
    assign w_word      = w_pos_ext[bfq_pkg::BIT_SEL_W +: bfq_pkg::WORD_AW];
    assign w_mask      = bfq_pkg::KEY_W'(1) << r_pos[bfq_pkg::BIT_SEL_W-1:0];
    assign w_hit       = |(w_ram_rdata & w_mask);

    // Filter RAM port control: clearing sweep or insert write-back.
    assign w_ram_re    = (r_state == S_READ);
    assign w_ram_we    = (r_state == S_CLEAR) ||
                         ((r_state == S_CHECK) && (r_mode == bfq_pkg::MODE_INSERT));
    assign w_ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : w_word;
    assign w_ram_wdata = (r_state == S_CLEAR) ? '0 : (w_ram_rdata | w_mask);

    bfq_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_hash),
        .i_divisor  (r_filter_bits),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    bfq_ram #(
        .WIDTH (bfq_pkg::KEY_W),
        .DEPTH (bfq_pkg::MAX_WORDS)
    ) u_filter_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_word),
        .o_rdata (w_ram_rdata)
    );

    // Sequencer next-state logic.
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_func     = r_func;
        n_valid    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == bfq_pkg::WORD_AW'(bfq_pkg::MAX_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_func = '0;
                if (w_run && (w_active != '0)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if ((r_mode == bfq_pkg::MODE_QUERY) && !w_hit) begin
                    n_state = S_IDLE;
                end else if (w_last) begin
                    n_state = S_IDLE;
                    n_valid = (r_mode == bfq_pkg::MODE_QUERY);
                end else begin
                    n_func  = r_func + 1'b1;
                    n_state = S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer state and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_func     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_func     <= n_func;
            r_valid    <= n_valid;
        end
    end

    // Item payload and intermediate hash values.
    always_ff @(posedge i_clk) begin
        if (w_run) begin
            r_mode <= i_mode;
            r_key  <= i_key;
        end
        if (r_state == S_MUL) begin
            r_prod <= w_prod;
        end
        if ((r_state == S_MOD) && w_mod_done) begin
            r_pos <= w_mod_rem;
        end
        if ((r_state == S_CHECK) && w_last) begin
            r_key_out <= r_key;
        end
    end

    // Configuration registers and the hash parameter tables.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_functions <= bfq_pkg::NUM_FUNCTIONS_RST;
            r_filter_bits   <= bfq_pkg::FILTER_BITS_RST;
            for (int i = 0; i < bfq_pkg::MAX_FUNCTIONS; i++) begin
                r_factor[i] <= '0;
                r_shift[i]  <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bfq_pkg::CFG_NUM_FUNCTIONS) begin
                    r_num_functions <= i_cfg_data[bfq_pkg::NUM_FUNC_W-1:0];
                end else if (i_cfg_index == bfq_pkg::CFG_FILTER_BITS) begin
                    r_filter_bits <= i_cfg_data;
                end
            end
            if (w_accept && (i_mode == bfq_pkg::MODE_LOAD)) begin
                r_factor[i_func_index] <= i_factor;
                r_shift[i_func_index]  <= i_shift_amount;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_key_out = r_key_out;

    // A passing key is only ever reported for a query.
    `BFQ_ASSERT_IMPLIES(a_valid_is_query, i_clk, i_rst_n, o_valid, r_mode == bfq_pkg::MODE_QUERY, "result strobe outside a query")
    // The result strobe lasts a single cycle.
    `BFQ_ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid, "result strobe held for more than one cycle")
    // An insert or query with functions enabled makes the block busy.
    `BFQ_ASSERT_NEXT(a_run_busy, i_clk, i_rst_n, w_run && (w_active != '0), o_busy, "accepted item did not raise busy")
    // Outside the clearing sweep the filter RAM is written only by an insert.
    `BFQ_ASSERT_IMPLIES(a_write_insert, i_clk, i_rst_n, w_ram_we && (r_state != S_CLEAR), r_mode == bfq_pkg::MODE_INSERT, "filter write outside an insert")

endmodule

`default_nettype wire
